// File: sv/dq_pkg.sv
// Shared constants, types and ring pointer arithmetic for the double-ended queue.
package dq_pkg;

	localparam int DEPTH = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam int VALUE_W = 32;
	localparam int MODE_W = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 11;
	localparam int M_TDATA_W = 48;
	localparam int M_PAD_W = M_TDATA_W - VALUE_W - COUNT_W - 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_HEAD = 3'd0,
		MODE_PUSH_TAIL = 3'd1,
		MODE_POP_HEAD  = 3'd2,
		MODE_POP_TAIL  = 3'd3,
		MODE_PEEK_HEAD = 3'd4,
		MODE_PEEK_TAIL = 3'd5,
		MODE_SIZE      = 3'd6,
		MODE_EMPTY     = 3'd7
	} dq_mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} dq_status_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_RESP
	} dq_state_t;

	typedef struct packed {
		logic exec;
	} dq_cmd_t;

	function automatic logic [ADDR_W-1:0] ring_add(
		input logic [ADDR_W-1:0] base,
		input logic [CNT_W-1:0] offset
	);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offset);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

// File: sv/dq_ctrl.sv
// Handshake controller for the double-ended queue: accepts one word, then holds its result.
module dq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output dq_pkg::dq_cmd_t cmd
);
	import dq_pkg::*;

	dq_state_t state_q;
	dq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			CTL_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.exec = 1'b1;
					state_d = CTL_RESP;
				end
			end
			CTL_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

endmodule

// File: sv/dq_datapath.sv
// Ring store, head pointer, entry count and result registers of the double-ended queue.
module dq_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dq_pkg::dq_cmd_t                  cmd,
	input  logic [dq_pkg::MODE_W-1:0]        mode,
	input  logic [dq_pkg::VALUE_W-1:0]       value,
	output logic [dq_pkg::VALUE_W-1:0]       data,
	output logic [dq_pkg::STATUS_W-1:0]      status,
	output logic [dq_pkg::COUNT_W-1:0]       count,
	output logic                             is_empty
);
	import dq_pkg::*;

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;

	dq_status_t       res_status_q;
	logic [CNT_W-1:0] res_count_q;
	logic             res_rd_q;

	logic [ADDR_W-1:0] head_d;
	logic [CNT_W-1:0]  count_d;
	dq_status_t        status_d;
	logic              we;
	logic              re;
	logic [ADDR_W-1:0] addr;
	logic              full;
	logic              empty;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		head_d = head_q;
		count_d = count_q;
		status_d = STATUS_OK;
		we = 1'b0;
		re = 1'b0;
		addr = head_q;
		case (dq_mode_t'(mode))
			MODE_PUSH_HEAD: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					head_d = ring_add(head_q, CNT_W'(DEPTH - 1));
					addr = head_d;
					we = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			MODE_PUSH_TAIL: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					addr = ring_add(head_q, count_q);
					we = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			MODE_POP_HEAD, MODE_PEEK_HEAD: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					re = 1'b1;
					addr = head_q;
					if (dq_mode_t'(mode) == MODE_POP_HEAD) begin
						head_d = ring_add(head_q, CNT_W'(1));
						count_d = count_q - 1'b1;
					end
				end
			end
			MODE_POP_TAIL, MODE_PEEK_TAIL: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					re = 1'b1;
					addr = ring_add(head_q, count_q - 1'b1);
					if (dq_mode_t'(mode) == MODE_POP_TAIL) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && we) begin
			mem[addr] <= value;
		end
		if (cmd.exec && re) begin
			rd_data_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= status_d;
			res_count_q <= count_d;
			res_rd_q <= re;
		end
	end

	assign data = res_rd_q ? rd_data_q : '0;
	assign status = res_status_q;
	assign count = COUNT_W'(res_count_q);
	assign is_empty = (res_count_q == '0);

endmodule

// File: sv/double_ended_queue.sv
// Top level of the double-ended queue: stream ports around controller and datapath.
//
// Bounded double-ended queue of 1024 signed 32-bit words. Each input word carries an
// operation in tuser and a value in tdata; each one produces exactly one result word with
// the popped or peeked data, a status in tuser, the entry count and an empty flag. In the
// accept cycle of an item the single port of the ring store is written or read, and in the
// next cycle the registered result is offered; a new word is taken in the cycle after the
// result is accepted, so the block takes no new word while a result is still pending.
// The store needs no clearing after reset, since only written entries are ever read.
module double_ended_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [dq_pkg::VALUE_W-1:0]     s_axis_tdata,  // value[31:0]
	input  logic [dq_pkg::MODE_W-1:0]      s_axis_tuser,  // mode[2:0]
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [dq_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // data[31:0], count[42:32], is_empty[43]
	output logic [dq_pkg::STATUS_W-1:0]    m_axis_tuser   // status[1:0]
);
	import dq_pkg::*;

	dq_cmd_t             cmd;
	logic [VALUE_W-1:0]  data;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	dq_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mode     (s_axis_tuser),
		.value    (s_axis_tdata),
		.data     (data),
		.status   (status),
		.count    (count),
		.is_empty (is_empty)
	);

	assign m_axis_tdata = {{M_PAD_W{1'b0}}, is_empty, count, data};
	assign m_axis_tuser = status;

endmodule

// File: dv/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: directed, fill and random stream tests.
module tb_double_ended_queue;
	import dq_pkg::*;

	typedef struct {
		logic [VALUE_W-1:0] data;
		dq_status_t status;
		logic [COUNT_W-1:0] count;
		logic is_empty;
	} dq_result_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [VALUE_W-1:0] s_axis_tdata;
	logic [MODE_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;

	logic [VALUE_W-1:0] deque_mem [DEPTH];
	int front_idx;
	int fill_level;
	dq_result_t pending_results[$];

	int err_count;
	bit idle_on;
	int hold_cycles;
	int stall_left;

	double_ended_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("double_ended_queue verification failed");
		$finish;
	end

	function automatic dq_result_t deque_apply(input dq_mode_t op, input logic [VALUE_W-1:0] val);
		dq_result_t res;
		int pos;
		res.data = '0;
		res.status = STATUS_OK;
		case (op)
			MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
				if (fill_level >= DEPTH) begin
					res.status = STATUS_FULL;
				end else if (op == MODE_PUSH_HEAD) begin
					front_idx = (front_idx + DEPTH - 1) % DEPTH;
					deque_mem[front_idx] = val;
					fill_level++;
				end else begin
					deque_mem[(front_idx + fill_level) % DEPTH] = val;
					fill_level++;
				end
			end
			MODE_POP_HEAD, MODE_PEEK_HEAD: begin
				if (fill_level == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					res.data = deque_mem[front_idx];
					if (op == MODE_POP_HEAD) begin
						front_idx = (front_idx + 1) % DEPTH;
						fill_level--;
					end
				end
			end
			MODE_POP_TAIL, MODE_PEEK_TAIL: begin
				if (fill_level == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					pos = (front_idx + fill_level - 1) % DEPTH;
					res.data = deque_mem[pos];
					if (op == MODE_POP_TAIL) begin
						fill_level--;
					end
				end
			end
			default: begin
			end
		endcase
		res.count = COUNT_W'(fill_level);
		res.is_empty = (fill_level == 0);
		return res;
	endfunction

	task automatic send_word(input dq_mode_t op, input logic [VALUE_W-1:0] val);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
		end
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= val;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		pending_results.insert(pending_results.size(), deque_apply(op, val));
	endtask

	// The receiver stalls in random bursts, or for a long stretch when a test asks for it.
	initial begin
		m_axis_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic report_field(input string field, input logic [VALUE_W-1:0] exp_val,
			input logic [VALUE_W-1:0] act_val);
		if (exp_val !== act_val) begin
			err_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val,
				act_val);
		end
	endtask

	initial begin
		dq_result_t exp_res;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					err_count++;
					$display("%0t: result word, expected none, actual %h/%h", $time,
						m_axis_tdata, m_axis_tuser);
				end else begin
					exp_res = pending_results[0];
					pending_results.delete(0);
					report_field("data", exp_res.data, m_axis_tdata[31:0]);
					report_field("status", VALUE_W'(exp_res.status), VALUE_W'(m_axis_tuser));
					report_field("count", VALUE_W'(exp_res.count), VALUE_W'(m_axis_tdata[42:32]));
					report_field("is_empty", VALUE_W'(exp_res.is_empty),
						VALUE_W'(m_axis_tdata[43]));
					report_field("padding", '0, VALUE_W'(m_axis_tdata[47:44]));
				end
			end
		end
	end

	task automatic test_empty_queue();
		send_word(MODE_POP_HEAD, 32'h1234_5678);
		send_word(MODE_POP_TAIL, 32'hFFFF_FFFF);
		send_word(MODE_PEEK_HEAD, 32'h0);
		send_word(MODE_PEEK_TAIL, 32'h8000_0000);
		send_word(MODE_SIZE, 32'h7FFF_FFFF);
		send_word(MODE_EMPTY, 32'hA5A5_A5A5);
	endtask

	task automatic test_both_ends();
		send_word(MODE_PUSH_HEAD, 32'h7FFF_FFFF);
		send_word(MODE_PUSH_TAIL, 32'h8000_0000);
		send_word(MODE_PUSH_HEAD, 32'hFFFF_FFFF);
		send_word(MODE_PUSH_TAIL, 32'h0);
		send_word(MODE_PEEK_HEAD, 32'h5555_5555);
		send_word(MODE_PEEK_TAIL, 32'hAAAA_AAAA);
		send_word(MODE_SIZE, 32'h0);
		send_word(MODE_EMPTY, 32'h0);
		send_word(MODE_POP_TAIL, 32'h0);
		send_word(MODE_POP_HEAD, 32'h0);
		send_word(MODE_POP_HEAD, 32'h0);
		send_word(MODE_POP_TAIL, 32'h0);
		send_word(MODE_EMPTY, 32'h0);
		send_word(MODE_POP_HEAD, 32'h0);
	endtask

	task automatic test_fill_and_overflow();
		hold_cycles = 400;
		while (fill_level < DEPTH) begin
			send_word($urandom_range(0, 1) ? MODE_PUSH_HEAD : MODE_PUSH_TAIL, $urandom);
		end
		send_word(MODE_PUSH_HEAD, $urandom);
		send_word(MODE_PUSH_TAIL, $urandom);
		send_word(MODE_PEEK_HEAD, $urandom);
		send_word(MODE_PEEK_TAIL, $urandom);
		send_word(MODE_SIZE, $urandom);
		send_word(MODE_EMPTY, $urandom);
	endtask

	task automatic test_random_mix(input int n_items);
		int pick;
		dq_mode_t op;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 23) op = MODE_PUSH_HEAD;
			else if (pick < 46) op = MODE_PUSH_TAIL;
			else if (pick < 61) op = MODE_POP_HEAD;
			else if (pick < 76) op = MODE_POP_TAIL;
			else if (pick < 84) op = MODE_PEEK_HEAD;
			else if (pick < 92) op = MODE_PEEK_TAIL;
			else if (pick < 96) op = MODE_SIZE;
			else op = MODE_EMPTY;
			send_word(op, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_SIZE;
		err_count = 0;
		idle_on = 1'b1;
		hold_cycles = 0;
		front_idx = 0;
		fill_level = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_queue();
		test_both_ends();
		test_fill_and_overflow();
		test_random_mix(160);
		idle_on = 1'b0;
		test_random_mix(60);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("double_ended_queue verification clean");
		end else begin
			$display("double_ended_queue verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/dq_pkg.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue.sv
dv/tb_double_ended_queue.sv
